// File: sv/gga_pkg.sv
// Package for the GGA position extractor: character codes, store depths and
// output run geometry. No dependencies; used by the top level module.
package gga_pkg;

	typedef logic [7:0] char_t;

	localparam char_t CH_DOLLAR = 8'h24;
	localparam char_t CH_CR     = 8'h0D;
	localparam char_t CH_COMMA  = 8'h2C;
	localparam char_t CH_POINT  = 8'h2E;
	localparam char_t CH_G      = 8'h47;
	localparam char_t CH_A      = 8'h41;

	localparam logic [23:0] GGA_TAG = {CH_G, CH_G, CH_A};

	localparam int LAT_LEN = 11;
	localparam int LON_LEN = 12;
	localparam int OUT_LEN = LAT_LEN + LON_LEN;
	localparam int LEN_W   = 4;
	localparam int CNT_W   = 5;
	localparam int TOK_W   = 3;

	localparam logic [LEN_W-1:0] LEN_SAT = 4'd13;
	localparam logic [TOK_W-1:0] TOK_SAT = 3'd7;
	localparam logic [TOK_W-1:0] TOK_LAT = 3'd2;
	localparam logic [TOK_W-1:0] TOK_LON = 3'd4;

	typedef logic [LEN_W-1:0] len_t;
	typedef logic [TOK_W-1:0] tok_t;
	typedef logic [CNT_W-1:0] cnt_t;

endpackage

// File: sv/nmea_gga_position_extractor.sv
// GGA position extractor top level: parses an NMEA byte stream and emits the
// reformatted latitude and longitude characters. Depends on gga_pkg.
//
//   channel  | dir | tdata          | tuser          | tlast
//   ---------+-----+----------------+----------------+-----------
//   s_axis   | in  | rx_byte [7:0]  | -              | -
//   m_axis   | out | out_char [7:0] | coord_kind [0] | last_char
//
// Each received byte is latched into an input register and processed from
// there, so one byte per cycle is taken while the input is not stalled.
// A carriage return that closes a valid GGA body copies 23 formatted characters
// into an output shift register, which then delivers one item per cycle while m_tready is high.
// Bytes keep being parsed while that run drains; only a second completed run
// waits in the input register until the output shift register has emptied.
// Reset (arst_n low) clears the sentence-type window, capture and token state
// and the output run; the coordinate stores need no reset.

module nmea_gga_position_extractor (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] rx_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_char
	output logic       m_tuser,   // [0] coord_kind
	output logic       m_tlast    // last_char
);

	localparam int LAT_LEN = gga_pkg::LAT_LEN;
	localparam int LON_LEN = gga_pkg::LON_LEN;
	localparam int OUT_LEN = gga_pkg::OUT_LEN;

	// Input register.
	gga_pkg::char_t rx_s1;
	logic           valid_s1;

	// Parser state.
	logic [23:0]    type_window_q;
	logic           capturing_q;
	logic           after_sep_q;
	gga_pkg::tok_t  token_count_q;
	gga_pkg::len_t  lat_length_q;
	gga_pkg::len_t  lon_length_q;
	gga_pkg::char_t lat_store_q [LAT_LEN];
	gga_pkg::char_t lon_store_q [LON_LEN];

	// Output run.
	gga_pkg::char_t snap_q [OUT_LEN];
	gga_pkg::cnt_t  cnt_q;
	logic           busy_q;

	logic           emit_req;
	logic           out_hs;
	logic           run_done;
	logic           stall;
	logic           advance;
	logic           load;
	gga_pkg::char_t fmt [OUT_LEN];

	// Token bookkeeping for an ordinary body character.
	gga_pkg::tok_t  tok_new;
	logic           lat_wr;
	logic           lon_wr;

	assign out_hs   = m_tvalid && m_tready;
	assign run_done = out_hs && (cnt_q == gga_pkg::cnt_t'(OUT_LEN - 1));

	// A run is requested by a carriage return inside a capture with both tokens
	// at their exact lengths.
	assign emit_req = capturing_q && (rx_s1 == gga_pkg::CH_CR)
		&& (lat_length_q == gga_pkg::len_t'(LAT_LEN))
		&& (lon_length_q == gga_pkg::len_t'(LON_LEN));

	// Only a new run can stall, and only while the previous run is still draining.
	assign stall    = valid_s1 && emit_req && busy_q && !run_done;
	assign advance  = valid_s1 && !stall;
	assign load     = advance && emit_req;
	assign s_tready = !valid_s1 || advance;

	always_comb begin
		tok_new = token_count_q;
		if (after_sep_q && token_count_q != gga_pkg::TOK_SAT) begin
			tok_new = token_count_q + gga_pkg::tok_t'(1);
		end
		lat_wr = (tok_new == gga_pkg::TOK_LAT);
		lon_wr = (tok_new == gga_pkg::TOK_LON);
	end

	// Formatted run: the decimal point moves after degree digit 2 of the
	// latitude and after degree digit 3 of the longitude; the character at the
	// old point position is dropped.
	always_comb begin
		for (int k = 0; k < LAT_LEN; k++) begin
			fmt[k] = lat_store_q[k];
		end
		fmt[2] = gga_pkg::CH_POINT;
		fmt[3] = lat_store_q[2];
		fmt[4] = lat_store_q[3];
		for (int k = 0; k < LON_LEN; k++) begin
			fmt[LAT_LEN + k] = lon_store_q[k];
		end
		fmt[LAT_LEN + 3] = gga_pkg::CH_POINT;
		fmt[LAT_LEN + 4] = lon_store_q[3];
		fmt[LAT_LEN + 5] = lon_store_q[4];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			rx_s1 <= s_tdata;
		end
	end

	// Parser control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_window_q <= '0;
			capturing_q   <= 1'b0;
			after_sep_q   <= 1'b1;
			token_count_q <= '0;
			lat_length_q  <= '0;
			lon_length_q  <= '0;
		end else if (advance) begin
			if (rx_s1 == gga_pkg::CH_DOLLAR) begin
				capturing_q <= 1'b0;
			end else if (capturing_q) begin
				if (rx_s1 == gga_pkg::CH_CR) begin
					capturing_q <= 1'b0;
				end else if (rx_s1 == gga_pkg::CH_COMMA) begin
					after_sep_q <= 1'b1;
				end else begin
					after_sep_q   <= 1'b0;
					token_count_q <= tok_new;
					if (lat_wr && lat_length_q != gga_pkg::LEN_SAT) begin
						lat_length_q <= lat_length_q + gga_pkg::len_t'(1);
					end
					if (lon_wr && lon_length_q != gga_pkg::LEN_SAT) begin
						lon_length_q <= lon_length_q + gga_pkg::len_t'(1);
					end
				end
			end else if (type_window_q == gga_pkg::GGA_TAG) begin
				// The byte after the sentence type is dropped and capture starts.
				capturing_q   <= 1'b1;
				type_window_q <= '0;
				after_sep_q   <= 1'b1;
				token_count_q <= '0;
				lat_length_q  <= '0;
				lon_length_q  <= '0;
			end else begin
				type_window_q <= {type_window_q[15:0], rx_s1};
			end
		end
	end

	// Coordinate stores; entries past the depth are simply not written.
	always_ff @(posedge clk) begin
		if (advance && capturing_q && rx_s1 != gga_pkg::CH_DOLLAR
			&& rx_s1 != gga_pkg::CH_CR && rx_s1 != gga_pkg::CH_COMMA) begin
			if (lat_wr && lat_length_q < gga_pkg::len_t'(LAT_LEN)) begin
				lat_store_q[lat_length_q] <= rx_s1;
			end
			if (lon_wr && lon_length_q < gga_pkg::len_t'(LON_LEN)) begin
				lon_store_q[lon_length_q] <= rx_s1;
			end
		end
	end

	// Output run control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (out_hs) begin
			busy_q <= !run_done;
			cnt_q  <= cnt_q + gga_pkg::cnt_t'(1);
		end
	end

	// Output shift register: the head is always the character on the bus.
	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < OUT_LEN; k++) begin
				snap_q[k] <= fmt[k];
			end
		end else if (out_hs) begin
			for (int k = 0; k < OUT_LEN - 1; k++) begin
				snap_q[k] <= snap_q[k + 1];
			end
		end
	end

	assign m_tvalid = busy_q;
	assign m_tdata  = snap_q[0];
	assign m_tuser  = (cnt_q >= gga_pkg::cnt_t'(LAT_LEN));
	assign m_tlast  = (cnt_q == gga_pkg::cnt_t'(OUT_LEN - 1));

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q <= gga_pkg::cnt_t'(OUT_LEN - 1))
		else $error("output run counter out of range");

	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (busy_q && cnt_q == '0))
		else $error("loaded run did not start at its first character");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(run_done && !load) |=> !busy_q)
		else $error("output run continued past its last character");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && busy_q && emit_req))
		else $error("input stalled without a pending run");
`endif

endmodule
